// ===== rtl/mdt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdt_pkg
// Shared constants, types and register codes of the multi-delimiter tokenizer.
// ----------------------------------------------------------------------------
package mdt_pkg;

    localparam int DELIM_SLOTS   = 4;
    localparam int MAX_DELIM_LEN = 8;
    localparam int BYTE_W        = 8;
    localparam int DELIM_W       = BYTE_W * MAX_DELIM_LEN;
    localparam int COUNT_W       = 3;
    localparam int LEN_FIELD_W   = 4;
    localparam int LENGTHS_W     = LEN_FIELD_W * DELIM_SLOTS;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 64;
    localparam int LEN_W         = $clog2(MAX_DELIM_LEN + 1);

    typedef logic [BYTE_W-1:0]                         t_byte;
    typedef logic [COUNT_W-1:0]                        t_count;
    typedef logic [DELIM_W-1:0]                        t_delim;
    typedef logic [LEN_FIELD_W-1:0]                    t_lfield;
    typedef logic [LENGTHS_W-1:0]                      t_lengths;
    typedef logic [CFG_IDX_W-1:0]                      t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0]                     t_cfg_data;
    typedef logic [LEN_W-1:0]                          t_len;
    typedef logic [DELIM_SLOTS-1:0]                    t_hit;
    typedef logic [MAX_DELIM_LEN-1:0]                  t_vld;
    typedef logic [DELIM_SLOTS-1:0][BYTE_W-1:0]        t_col;
    typedef logic [MAX_DELIM_LEN-1:0][DELIM_SLOTS-1:0] t_hit_arr;
    typedef logic [MAX_DELIM_LEN-1:0][BYTE_W-1:0]      t_byte_arr;
    typedef logic [MAX_DELIM_LEN-1:0][DELIM_SLOTS-1:0][BYTE_W-1:0] t_col_arr;

    typedef struct packed {
        logic found;
        t_len len;
    } t_match;

    localparam t_cfg_idx CFG_COUNT   = t_cfg_idx'(0);
    localparam t_cfg_idx CFG_DELIM0  = t_cfg_idx'(1);
    localparam t_cfg_idx CFG_DELIM1  = t_cfg_idx'(2);
    localparam t_cfg_idx CFG_DELIM2  = t_cfg_idx'(3);
    localparam t_cfg_idx CFG_DELIM3  = t_cfg_idx'(4);
    localparam t_cfg_idx CFG_LENGTHS = t_cfg_idx'(5);

    localparam t_count   RST_COUNT   = t_count'(1);
    localparam t_delim   RST_DELIM0  = t_delim'(32);
    localparam t_lengths RST_LENGTHS = t_lengths'(1);

    localparam t_vld VLD_TOP = t_vld'(1) << (MAX_DELIM_LEN - 1);

endpackage

// ===== rtl/mdt_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdt_if
// Valid/ready channels of the tokenizer: input bytes, results, config writes.
// ----------------------------------------------------------------------------
interface mdt_in_if;
    logic          valid;
    logic          ready;
    mdt_pkg::t_byte in_byte;
    logic          line_end;
    logic          byte_present;

    modport source (output valid, output in_byte, output line_end, output byte_present,
                    input ready);
    modport sink   (input valid, input in_byte, input line_end, input byte_present,
                    output ready);
endinterface

interface mdt_out_if;
    logic          valid;
    logic          ready;
    mdt_pkg::t_byte out_byte;
    logic          out_valid;
    logic          token_last;
    logic          line_done;

    modport source (output valid, output out_byte, output out_valid, output token_last,
                    output line_done, input ready);
    modport sink   (input valid, input out_byte, input out_valid, input token_last,
                    input line_done, output ready);
endinterface

interface mdt_cfg_if;
    logic               valid;
    logic               ready;
    mdt_pkg::t_cfg_idx  index;
    mdt_pkg::t_cfg_data data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/mdt_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdt_cell
// One window cell: holds a byte and its valid bit, takes its neighbor's byte
// on shift, and compares its byte against the same position of every
// delimiter.
// ----------------------------------------------------------------------------
module mdt_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_shift,
    input  mdt_pkg::t_byte i_byte,
    input  logic           i_valid,
    input  mdt_pkg::t_col  i_col,
    output mdt_pkg::t_byte o_byte,
    output logic           o_valid,
    output mdt_pkg::t_hit  o_hit
);

    mdt_pkg::t_byte r_byte;
    logic           r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_shift) begin
            r_valid <= i_valid;
            r_byte  <= i_byte;
        end
    end

    always_comb begin
        for (int i = 0; i < mdt_pkg::DELIM_SLOTS; i++) begin
            o_hit[i] = (r_byte == i_col[i]);
        end
    end

    assign o_byte  = r_byte;
    assign o_valid = r_valid;

endmodule

// ===== rtl/mdt_match.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdt_match
// Picks the winning delimiter at the window head from the per-cell compare
// results: lowest index wins, length saturated, short tail never matches.
// ----------------------------------------------------------------------------
module mdt_match (
    input  mdt_pkg::t_hit_arr i_hit,
    input  mdt_pkg::t_vld     i_valid,
    input  mdt_pkg::t_count   i_count,
    input  mdt_pkg::t_lengths i_lengths,
    output mdt_pkg::t_match   o_match
);

    always_comb begin
        mdt_pkg::t_lfield fld;
        mdt_pkg::t_len    len;
        logic             ok;
        o_match = '0;
        for (int i = mdt_pkg::DELIM_SLOTS - 1; i >= 0; i--) begin
            fld = i_lengths[mdt_pkg::LEN_FIELD_W*i +: mdt_pkg::LEN_FIELD_W];
            if (fld > mdt_pkg::t_lfield'(mdt_pkg::MAX_DELIM_LEN)) begin
                len = mdt_pkg::t_len'(mdt_pkg::MAX_DELIM_LEN);
            end else begin
                len = mdt_pkg::t_len'(fld);
            end
            ok = (fld != '0) && (int'(i_count) > i);
            for (int j = 0; j < mdt_pkg::MAX_DELIM_LEN; j++) begin
                if (j < int'(len)) begin
                    ok = ok & i_hit[j][i] & i_valid[j];
                end
            end
            if (ok) begin
                o_match.found = 1'b1;
                o_match.len   = len;
            end
        end
    end

endmodule

// ===== rtl/multi_delimiter_tokenizer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_delimiter_tokenizer_top
// Output: a token byte is held back until the next head of the 8-cell window
//   is decided or the line ends, and is then registered at the output.
// Throughput: one byte per cycle while the output drains; end of line flushes
//   the window (cell shifts, then the done marker) with input held.
// Reset: synchronous, active low; clears cell valid bits, token and skip state,
//   the output register, and restores the default delimiter configuration.
// ----------------------------------------------------------------------------
module multi_delimiter_tokenizer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mdt_cfg_if.sink     i_cfg,
    mdt_in_if.sink      i_in,
    mdt_out_if.source   o_out
);

    typedef enum logic {ST_RUN, ST_FLUSH} t_state;

    t_state                                  r_state, n_state;
    mdt_pkg::t_count                         r_count;
    logic [mdt_pkg::DELIM_SLOTS-1:0][mdt_pkg::DELIM_W-1:0] r_delim;
    mdt_pkg::t_lengths                       r_lengths;
    logic                                    r_head_done, n_head_done;
    mdt_pkg::t_len                           r_skip, n_skip;
    logic                                    r_tok_open, n_tok_open;
    mdt_pkg::t_byte                          r_tail, n_tail;
    logic                                    r_ov;
    mdt_pkg::t_byte                          r_out_byte;
    logic                                    r_out_valid;
    logic                                    r_token_last;
    logic                                    r_line_done;

    mdt_pkg::t_byte_arr w_byte, w_nbyte;
    mdt_pkg::t_vld      w_valid, w_nvld;
    mdt_pkg::t_hit_arr  w_hit;
    mdt_pkg::t_col_arr  w_col;
    mdt_pkg::t_match    w_match;

    logic           w_empty, w_can_emit, w_head_pend, w_decide, w_final;
    logic           w_in_acc, w_shift, w_emit;
    mdt_pkg::t_byte w_e_byte;
    logic           w_e_valid, w_e_last, w_e_done;

    // window chain: bytes enter at the top cell and move toward cell 0
    always_comb begin
        for (int k = 0; k < mdt_pkg::MAX_DELIM_LEN; k++) begin
            for (int i = 0; i < mdt_pkg::DELIM_SLOTS; i++) begin
                w_col[k][i] = r_delim[i][mdt_pkg::BYTE_W*k +: mdt_pkg::BYTE_W];
            end
        end
        for (int k = 0; k < mdt_pkg::MAX_DELIM_LEN - 1; k++) begin
            w_nbyte[k] = w_byte[k+1];
            w_nvld[k]  = w_valid[k+1];
        end
        w_nbyte[mdt_pkg::MAX_DELIM_LEN-1] = i_in.in_byte;
        w_nvld[mdt_pkg::MAX_DELIM_LEN-1]  = (r_state == ST_RUN);
    end

    for (genvar k = 0; k < mdt_pkg::MAX_DELIM_LEN; k++) begin : g_cell
        mdt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_shift),
            .i_byte  (w_nbyte[k]),
            .i_valid (w_nvld[k]),
            .i_col   (w_col[k]),
            .o_byte  (w_byte[k]),
            .o_valid (w_valid[k]),
            .o_hit   (w_hit[k])
        );
    end

    mdt_match u_match (
        .i_hit     (w_hit),
        .i_valid   (w_valid),
        .i_count   (r_count),
        .i_lengths (r_lengths),
        .o_match   (w_match)
    );

    assign w_empty     = (w_valid == '0);
    assign w_can_emit  = !r_ov || o_out.ready;
    assign w_head_pend = w_valid[0] && !r_head_done;
    assign w_decide    = w_head_pend && w_can_emit;
    assign w_final     = (r_state == ST_FLUSH) && w_empty && w_can_emit;
    assign w_in_acc    = i_in.valid && i_in.ready;

    assign i_in.ready  = (r_state == ST_RUN) && (!w_head_pend || w_can_emit);
    assign i_cfg.ready = 1'b1;

    always_comb begin
        case (r_state)
            ST_RUN:   w_shift = w_in_acc && i_in.byte_present;
            ST_FLUSH: w_shift = !w_empty && (!w_head_pend || w_can_emit);
            default:  w_shift = 1'b0;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_skip      = r_skip;
        n_tok_open  = r_tok_open;
        n_tail      = r_tail;
        n_head_done = r_head_done;
        w_emit      = 1'b0;
        w_e_byte    = '0;
        w_e_valid   = 1'b0;
        w_e_last    = 1'b0;
        w_e_done    = 1'b0;
        if (w_decide) begin
            if (r_skip != '0) begin
                n_skip = r_skip - mdt_pkg::t_len'(1);
            end else if (w_match.found) begin
                if (r_tok_open) begin
                    w_emit    = 1'b1;
                    w_e_byte  = r_tail;
                    w_e_valid = 1'b1;
                    w_e_last  = 1'b1;
                end
                n_tok_open = 1'b0;
                n_skip     = w_match.len - mdt_pkg::t_len'(1);
            end else begin
                if (r_tok_open) begin
                    w_emit    = 1'b1;
                    w_e_byte  = r_tail;
                    w_e_valid = 1'b1;
                end
                n_tail     = w_byte[0];
                n_tok_open = 1'b1;
            end
        end
        if (w_final) begin
            w_emit     = 1'b1;
            w_e_byte   = r_tok_open ? r_tail : '0;
            w_e_valid  = r_tok_open;
            w_e_last   = r_tok_open;
            w_e_done   = 1'b1;
            n_tok_open = 1'b0;
            n_state    = ST_RUN;
        end
        if (w_in_acc && i_in.line_end) begin
            n_state = ST_FLUSH;
        end
        if (w_shift) begin
            n_head_done = 1'b0;
        end else if (w_decide) begin
            n_head_done = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RUN;
            r_head_done <= 1'b0;
            r_skip      <= '0;
            r_tok_open  <= 1'b0;
            r_ov        <= 1'b0;
            r_count     <= mdt_pkg::RST_COUNT;
            r_lengths   <= mdt_pkg::RST_LENGTHS;
            r_delim[0]  <= mdt_pkg::RST_DELIM0;
            for (int i = 1; i < mdt_pkg::DELIM_SLOTS; i++) begin
                r_delim[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_head_done <= n_head_done;
            r_skip      <= n_skip;
            r_tok_open  <= n_tok_open;
            r_tail      <= n_tail;
            if (w_emit) begin
                r_ov         <= 1'b1;
                r_out_byte   <= w_e_byte;
                r_out_valid  <= w_e_valid;
                r_token_last <= w_e_last;
                r_line_done  <= w_e_done;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    mdt_pkg::CFG_COUNT:   r_count    <= mdt_pkg::t_count'(i_cfg.data);
                    mdt_pkg::CFG_DELIM0:  r_delim[0] <= mdt_pkg::t_delim'(i_cfg.data);
                    mdt_pkg::CFG_DELIM1:  r_delim[1] <= mdt_pkg::t_delim'(i_cfg.data);
                    mdt_pkg::CFG_DELIM2:  r_delim[2] <= mdt_pkg::t_delim'(i_cfg.data);
                    mdt_pkg::CFG_DELIM3:  r_delim[3] <= mdt_pkg::t_delim'(i_cfg.data);
                    mdt_pkg::CFG_LENGTHS: r_lengths  <= mdt_pkg::t_lengths'(i_cfg.data);
                    default: ;
                endcase
            end
        end
    end

    assign o_out.valid      = r_ov;
    assign o_out.out_byte   = r_out_byte;
    assign o_out.out_valid  = r_out_valid;
    assign o_out.token_last = r_token_last;
    assign o_out.line_done  = r_line_done;

    a_skip_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skip != '0) |-> !r_tok_open)
        else $error("token open while delimiter bytes are being skipped");

    a_done_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head_done |-> w_valid[0])
        else $error("head marked decided but head cell empty");

    a_run_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |->
            ((w_valid & ~((w_valid >> 1) | mdt_pkg::VLD_TOP)) == '0))
        else $error("window bytes not packed against the tail cell");

    a_final_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_final |=> (r_state == ST_RUN) && r_ov && r_line_done)
        else $error("end-of-line transaction not registered after flush");

endmodule

// ===== bench/tb_multi_delimiter_tokenizer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multi_delimiter_tokenizer_top
// Self-checking bench for the multi-delimiter line tokenizer. A byte driver
// and a result monitor run as clocked processes with random gaps and stalls.
// A predictor mirrors the lookahead window and held-back token byte, and
// every result transaction is compared field by field. The delimiter
// configuration is reprogrammed between phases, extremes included.
// ----------------------------------------------------------------------------
module tb_multi_delimiter_tokenizer_top;

    localparam int RST_CYCLES    = 6;
    localparam int SETTLE_CYCLES = 20;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int HOLD_CYCLES   = 150;
    localparam int RAND_PHASES   = 5;
    localparam int PHASE_ITEMS   = 14;

    typedef struct packed {
        mdt_pkg::t_byte data;
        logic           line_end;
        logic           present;
    } t_line_item;

    typedef struct packed {
        mdt_pkg::t_byte data;
        logic           valid;
        logic           last;
        logic           done;
    } t_token_beat;

    logic i_clk;
    logic i_rst_n = 1'b0;

    mdt_in_if  in_if ();
    mdt_out_if out_if ();
    mdt_cfg_if cfg_if ();

    multi_delimiter_tokenizer_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_line_item  pending_bytes[$];
    t_token_beat expected_tokens[$];

    mdt_pkg::t_count   m_count;
    mdt_pkg::t_delim   m_delim [mdt_pkg::DELIM_SLOTS];
    mdt_pkg::t_lengths m_lengths;

    mdt_pkg::t_byte win [mdt_pkg::MAX_DELIM_LEN];
    int             win_fill = 0;
    bit             tok_open = 1'b0;
    mdt_pkg::t_byte tok_tail = '0;

    mdt_pkg::t_byte alpha [4];

    bit in_gaps_on    = 1'b1;
    bit out_stalls_on = 1'b1;
    int in_gap        = 0;
    int out_stall     = 0;
    int n_taken       = 0;
    int hold_at       = 32'h7fff_ffff;
    int hold_left     = 0;
    bit hold_used     = 1'b0;
    int cycle_count   = 0;
    int n_fail        = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int active_len(int i);
        int n;
        int len;
        n = int'(m_count);
        if (n > mdt_pkg::DELIM_SLOTS) n = mdt_pkg::DELIM_SLOTS;
        if (i >= n) return 0;
        len = int'(m_lengths[mdt_pkg::LEN_FIELD_W*i +: mdt_pkg::LEN_FIELD_W]);
        if (len > mdt_pkg::MAX_DELIM_LEN) len = mdt_pkg::MAX_DELIM_LEN;
        return len;
    endfunction

    function automatic int winning_len(int avail);
        int len;
        bit hit;
        for (int i = 0; i < mdt_pkg::DELIM_SLOTS; i++) begin
            len = active_len(i);
            if (len == 0 || len > avail) continue;
            hit = 1'b1;
            for (int j = 0; j < len; j++) begin
                if (win[j] != m_delim[i][mdt_pkg::BYTE_W*j +: mdt_pkg::BYTE_W]) hit = 1'b0;
            end
            if (hit) return len;
        end
        return 0;
    endfunction

    function automatic void expect_beat(mdt_pkg::t_byte b, logic v, logic l, logic d);
        t_token_beat t;
        t.data  = b;
        t.valid = v;
        t.last  = l;
        t.done  = d;
        expected_tokens.insert(expected_tokens.size(), t);
    endfunction

    function automatic void consume_head(int avail);
        int k;
        k = winning_len(avail);
        if (k != 0) begin
            if (tok_open) expect_beat(tok_tail, 1'b1, 1'b1, 1'b0);
            tok_open = 1'b0;
        end else begin
            if (tok_open) expect_beat(tok_tail, 1'b1, 1'b0, 1'b0);
            tok_tail = win[0];
            tok_open = 1'b1;
            k = 1;
        end
        for (int j = 0; j < win_fill - k; j++) win[j] = win[j+k];
        win_fill -= k;
    endfunction

    function automatic void tokenize_byte(mdt_pkg::t_byte b, logic eol, logic present);
        if (present) begin
            if (win_fill >= mdt_pkg::MAX_DELIM_LEN) consume_head(mdt_pkg::MAX_DELIM_LEN);
            win[win_fill] = b;
            win_fill++;
        end
        if (!eol) begin
            if (win_fill >= mdt_pkg::MAX_DELIM_LEN) consume_head(mdt_pkg::MAX_DELIM_LEN);
            return;
        end
        while (win_fill > 0) consume_head(win_fill);
        if (tok_open) expect_beat(tok_tail, 1'b1, 1'b1, 1'b1);
        else expect_beat('0, 1'b0, 1'b0, 1'b1);
        tok_open = 1'b0;
        tok_tail = '0;
    endfunction

    function automatic int next_gap(bit on);
        int r;
        if (!on) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(6, 24);
    endfunction

    function automatic t_line_item make_item(mdt_pkg::t_byte b, logic eol, logic present);
        t_line_item it;
        it.data     = b;
        it.line_end = eol;
        it.present  = present;
        return it;
    endfunction

    function automatic mdt_pkg::t_byte pick_byte();
        int r;
        int d;
        int j;
        r = $urandom_range(0, 9);
        if (r < 5) return alpha[$urandom_range(0, 3)];
        d = $urandom_range(0, mdt_pkg::DELIM_SLOTS-1);
        j = $urandom_range(0, mdt_pkg::MAX_DELIM_LEN-1);
        if (r < 8) return m_delim[d][mdt_pkg::BYTE_W*j +: mdt_pkg::BYTE_W];
        return mdt_pkg::t_byte'($urandom);
    endfunction

    function automatic mdt_pkg::t_delim str_word(string s);
        mdt_pkg::t_delim w;
        w = '0;
        for (int i = 0; i < s.len() && i < mdt_pkg::MAX_DELIM_LEN; i++) begin
            w[mdt_pkg::BYTE_W*i +: mdt_pkg::BYTE_W] = s[i];
        end
        return w;
    endfunction

    task automatic push_line(string s, bit end_on_last);
        for (int i = 0; i < s.len(); i++) begin
            pending_bytes.insert(pending_bytes.size(),
                                 make_item(s[i], end_on_last && (i == s.len() - 1), 1'b1));
        end
    endtask

    task automatic write_reg(mdt_pkg::t_cfg_idx idx, mdt_pkg::t_cfg_data val);
        @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        case (idx)
            mdt_pkg::CFG_COUNT:   m_count    = val[mdt_pkg::COUNT_W-1:0];
            mdt_pkg::CFG_DELIM0:  m_delim[0] = val;
            mdt_pkg::CFG_DELIM1:  m_delim[1] = val;
            mdt_pkg::CFG_DELIM2:  m_delim[2] = val;
            mdt_pkg::CFG_DELIM3:  m_delim[3] = val;
            mdt_pkg::CFG_LENGTHS: m_lengths  = val[mdt_pkg::LENGTHS_W-1:0];
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        while (pending_bytes.size() != 0 || in_if.valid || expected_tokens.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_phase(int k);
        mdt_pkg::t_delim   w [mdt_pkg::DELIM_SLOTS];
        mdt_pkg::t_lengths lens;
        mdt_pkg::t_count   cnt;
        for (int i = 0; i < 4; i++) alpha[i] = mdt_pkg::t_byte'($urandom);
        for (int i = 0; i < mdt_pkg::DELIM_SLOTS; i++) begin
            w[i] = {$urandom, $urandom};
            if (k == 0 || k == 4) begin
                for (int j = 0; j < mdt_pkg::MAX_DELIM_LEN; j++) begin
                    w[i][mdt_pkg::BYTE_W*j +: mdt_pkg::BYTE_W] = alpha[$urandom_range(0, 3)];
                end
            end
            lens[mdt_pkg::LEN_FIELD_W*i +: mdt_pkg::LEN_FIELD_W] =
                mdt_pkg::t_lfield'($urandom_range(0, 4));
        end
        case (k)
            0: begin
                cnt = mdt_pkg::t_count'(4);
                for (int i = 0; i < mdt_pkg::DELIM_SLOTS; i++) begin
                    lens[mdt_pkg::LEN_FIELD_W*i +: mdt_pkg::LEN_FIELD_W] =
                        mdt_pkg::t_lfield'($urandom_range(1, 3));
                end
            end
            1: begin
                cnt  = mdt_pkg::t_count'(7);
                lens = '1;
                w[0] = '1;
                w[1] = '0;
            end
            2: begin
                cnt = mdt_pkg::t_count'(1);
                lens[mdt_pkg::LEN_FIELD_W-1:0] = mdt_pkg::t_lfield'(mdt_pkg::MAX_DELIM_LEN);
            end
            3: begin
                cnt  = mdt_pkg::t_count'($urandom_range(0, 7));
                lens = mdt_pkg::t_lengths'($urandom);
            end
            default: cnt = mdt_pkg::t_count'($urandom_range(2, 4));
        endcase
        write_reg(mdt_pkg::CFG_COUNT,   mdt_pkg::t_cfg_data'(cnt));
        write_reg(mdt_pkg::CFG_DELIM0,  w[0]);
        write_reg(mdt_pkg::CFG_DELIM1,  w[1]);
        write_reg(mdt_pkg::CFG_DELIM2,  w[2]);
        write_reg(mdt_pkg::CFG_DELIM3,  w[3]);
        write_reg(mdt_pkg::CFG_LENGTHS, mdt_pkg::t_cfg_data'(lens));
    endtask

    task automatic queue_random_line(output int n_real);
        t_line_item line[$];
        int         pieces;
        int         r;
        int         d;
        int         len;
        int         cnt;
        pieces = $urandom_range(0, 6);
        for (int p = 0; p < pieces; p++) begin
            r   = $urandom_range(0, 99);
            d   = $urandom_range(0, mdt_pkg::DELIM_SLOTS-1);
            len = active_len(d);
            if (r < 55 && len != 0) begin
                cnt = (r < 40) ? len : $urandom_range(1, len);
                for (int j = 0; j < cnt; j++) begin
                    line.insert(line.size(), make_item(
                        m_delim[d][mdt_pkg::BYTE_W*j +: mdt_pkg::BYTE_W], 1'b0, 1'b1));
                end
            end else begin
                cnt = $urandom_range(1, 4);
                for (int j = 0; j < cnt; j++) begin
                    line.insert(line.size(), make_item(pick_byte(), 1'b0, 1'b1));
                end
            end
            if ($urandom_range(0, 24) == 0) begin
                line.insert(line.size(), make_item(mdt_pkg::t_byte'($urandom), 1'b0, 1'b0));
            end
        end
        if (line.size() == 0 || $urandom_range(0, 3) == 0) begin
            line.insert(line.size(), make_item(mdt_pkg::t_byte'($urandom), 1'b1, 1'b0));
        end else begin
            line[$].line_end = 1'b1;
        end
        n_real = 0;
        foreach (line[i]) begin
            if (line[i].present || line[i].line_end) n_real++;
            pending_bytes.insert(pending_bytes.size(), line[i]);
        end
    endtask

    always @(posedge i_clk) begin
        t_line_item nxt;
        if (!i_rst_n) begin
            in_if.valid        <= 1'b0;
            in_if.in_byte      <= '0;
            in_if.line_end     <= 1'b0;
            in_if.byte_present <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                tokenize_byte(in_if.in_byte, in_if.line_end, in_if.byte_present);
                n_taken <= n_taken + 1;
            end
            if (!in_if.valid || in_if.ready) begin
                if (in_gap != 0) begin
                    in_gap--;
                    in_if.valid <= 1'b0;
                end else if (pending_bytes.size() != 0) begin
                    nxt = pending_bytes.pop_front();
                    in_if.in_byte      <= nxt.data;
                    in_if.line_end     <= nxt.line_end;
                    in_if.byte_present <= nxt.present;
                    in_if.valid        <= 1'b1;
                    in_gap = next_gap(in_gaps_on);
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_token_beat exp;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (expected_tokens.size() == 0) begin
                    $error("unexpected result: out_byte=%02h out_valid=%0b %s=%0b %s=%0b",
                           out_if.out_byte, out_if.out_valid, "token_last",
                           out_if.token_last, "line_done", out_if.line_done);
                    n_fail++;
                end else begin
                    exp = expected_tokens.pop_front();
                    if (out_if.out_byte !== exp.data) begin
                        $error("out_byte: expected %02h, got %02h", exp.data, out_if.out_byte);
                        n_fail++;
                    end
                    if (out_if.out_valid !== exp.valid) begin
                        $error("out_valid: expected %0b, got %0b", exp.valid, out_if.out_valid);
                        n_fail++;
                    end
                    if (out_if.token_last !== exp.last) begin
                        $error("token_last: expected %0b, got %0b", exp.last, out_if.token_last);
                        n_fail++;
                    end
                    if (out_if.line_done !== exp.done) begin
                        $error("line_done: expected %0b, got %0b", exp.done, out_if.line_done);
                        n_fail++;
                    end
                end
            end
            if (hold_left != 0) begin
                out_if.ready <= 1'b0;
            end else if (out_stall != 0) begin
                out_stall--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
                out_stall = next_gap(out_stalls_on);
            end
        end
    end

    // hold off the result side once, long enough to back up the input
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_used <= 1'b0;
        end else if (!hold_used && n_taken >= hold_at) begin
            hold_left <= HOLD_CYCLES;
            hold_used <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** multi_delimiter_tokenizer_top: FAILED **");
            $finish;
        end
    end

    initial begin
        int got;
        int n_line;
        cfg_if.valid = 1'b0;
        cfg_if.index = mdt_pkg::CFG_COUNT;
        cfg_if.data  = '0;
        m_count    = mdt_pkg::RST_COUNT;
        m_delim[0] = mdt_pkg::RST_DELIM0;
        m_delim[1] = '0;
        m_delim[2] = '0;
        m_delim[3] = '0;
        m_lengths  = mdt_pkg::RST_LENGTHS;
        for (int i = 0; i < 4; i++) alpha[i] = mdt_pkg::t_byte'($urandom);

        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // default single space delimiter: runs, an empty line, delimiter-only line
        push_line("a  b", 1'b1);
        pending_bytes.insert(pending_bytes.size(), make_item(8'hA5, 1'b1, 1'b0));
        pending_bytes.insert(pending_bytes.size(), make_item(8'h5A, 1'b0, 1'b0));
        push_line(" ", 1'b1);
        push_line("xy ", 1'b0);
        pending_bytes.insert(pending_bytes.size(), make_item(8'hFF, 1'b1, 1'b0));
        wait_idle();

        // saturated count, priority between overlapping delimiters,
        // zero length and oversized length fields
        write_reg(mdt_pkg::CFG_COUNT,   mdt_pkg::t_cfg_data'(7));
        write_reg(mdt_pkg::CFG_DELIM0,  str_word("ab"));
        write_reg(mdt_pkg::CFG_DELIM1,  str_word("a"));
        write_reg(mdt_pkg::CFG_DELIM2,  str_word("q"));
        write_reg(mdt_pkg::CFG_DELIM3,  str_word("zzzzzzzz"));
        write_reg(mdt_pkg::CFG_LENGTHS, mdt_pkg::t_cfg_data'(16'hF012));
        push_line("qabaq", 1'b1);
        wait_idle();

        // no delimiter in use: whole line is one token
        write_reg(mdt_pkg::CFG_COUNT, mdt_pkg::t_cfg_data'(0));
        push_line("a b", 1'b1);
        wait_idle();

        for (int k = 0; k < RAND_PHASES; k++) begin
            in_gaps_on    = (k != 2);
            out_stalls_on = (k != 2);
            program_phase(k);
            if (k == 0) hold_at = n_taken + 3;
            got = 0;
            while (got < PHASE_ITEMS) begin
                queue_random_line(n_line);
                got += n_line;
            end
            wait_idle();
        end

        if (n_fail == 0) begin
            $display("** multi_delimiter_tokenizer_top: PASSED **");
        end else begin
            $display("** multi_delimiter_tokenizer_top: FAILED **");
        end
        $finish;
    end

endmodule

// ===== multi_delimiter_tokenizer_top.f =====
rtl/mdt_pkg.sv
rtl/mdt_if.sv
rtl/mdt_cell.sv
rtl/mdt_match.sv
rtl/multi_delimiter_tokenizer_top.sv
bench/tb_multi_delimiter_tokenizer_top.sv
